// ----- src/jddm_pkg.sv -----
// ----------------------------------------------------------------------------
// jddm_pkg - joystick mixer shared definitions
// Fixed-point constants, pipeline payload types and the arithmetic helpers
// used by the mixer datapath.
// ----------------------------------------------------------------------------
package jddm_pkg;

  localparam int unsigned FracBits   = 14;
  localparam int unsigned NumStages  = 15;
  localparam int unsigned DivStages  = 7;
  localparam int unsigned DivPerStep = 2;

  localparam logic signed [15:0] OneS     = 16'sd16384;
  localparam logic        [14:0] OneU     = 15'd16384;
  localparam logic        [9:0]  PwmFull  = 10'd1023;
  localparam logic signed [11:0] PwmFullS = 12'sd1023;
  localparam logic        [14:0] CorrReset = 15'd16384;
  localparam logic        [25:0] CorrHalf  = 26'd8192;

  localparam int unsigned CfgAddrW = 8;
  localparam logic [CfgAddrW-1:0] CFG_LEFT_CORR  = 8'd0;
  localparam logic [CfgAddrW-1:0] CFG_RIGHT_CORR = 8'd1;

  // Divider payload: quotient of |x| * ONE / (|x| + |y| + 1) built bit by bit.
  typedef struct packed {
    logic signed [15:0] x;
    logic               y_neg;
    logic        [14:0] ay;
    logic        [15:0] den;
    logic        [15:0] rem;
    logic        [13:0] quo;
  } div_t;

  function automatic logic signed [15:0] sat_axis(logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > OneS) begin
      r = OneS;
    end else if (v < -OneS) begin
      r = -OneS;
    end
    return r;
  endfunction

  // Two restoring-division steps; remainder always stays below the divisor.
  function automatic div_t div_step2(div_t a);
    div_t        r;
    logic [16:0] sh;
    r = a;
    for (int i = 0; i < DivPerStep; i++) begin
      sh = {r.rem, 1'b0};
      if (sh >= {1'b0, r.den}) begin
        r.rem = 16'(sh - {1'b0, r.den});
        r.quo = {r.quo[12:0], 1'b1};
      end else begin
        r.rem = sh[15:0];
        r.quo = {r.quo[12:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Divide by ONE, truncating toward zero.
  function automatic logic signed [17:0] div_one_tz(logic signed [31:0] s);
    logic signed [31:0] b;
    b = s + ((s < 0) ? 32'sd16383 : 32'sd0);
    return 18'(b >>> FracBits);
  endfunction

endpackage

// ----- src/joystick_differential_drive_mixer.sv -----
// ----------------------------------------------------------------------------
// joystick_differential_drive_mixer - arc/tank blending wheel mixer
// Turns one joystick sample into bridge direction lines and corrected PWM
// duties for a two-motor differential drive.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis_*: one stick sample per item, stick_x in tdata[15:0]
//   and stick_y in tdata[31:16], Q2.14, saturated to +/-1.0 internally.
//   Output channel m_axis_*: one result item per sample, 24 bits of tdata.
//   Config channel cfg_*: index 0 writes left_correction, index 1 writes
//   right_correction (Q1.14); other indexes are dropped. cfg_ready_o is
//   always high. Write only while the pipeline is empty.
//   Throughput: one item per cycle while the output is not stalled.
//   The depth is set mostly by the seven two-bit stages of the restoring
//   divider that forms the arc ratio.
//   Reset: all stage valid bits clear, both corrections return to unity.
//   Stall: each stage holds while the one below is full and stalled, so
//   bubbles close up; s_axis_tready drops only when all 15 stages are full
//   and the output is stalled. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module joystick_differential_drive_mixer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] stick_x, [31:16] stick_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] left_in_one, [1] left_in_two, [11:2] left_duty,
  // [12] right_in_one, [13] right_in_two, [23:14] right_duty
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [jddm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [14:0] cfg_data_i
);
  import jddm_pkg::*;

  // Stage valid bits and advance enables
  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] adv;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Configuration registers
  logic [14:0] lcorr_q, rcorr_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcorr_q <= CorrReset;
      rcorr_q <= CorrReset;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_LEFT_CORR:  lcorr_q <= cfg_data_i;
        CFG_RIGHT_CORR: rcorr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 0: saturate, take magnitudes, form the divisor
  logic signed [15:0] in_x, in_y;
  logic        [14:0] in_ax, in_ay;
  div_t               div_in;

  always_comb begin
    in_x        = sat_axis($signed(s_axis_tdata[15:0]));
    in_y        = sat_axis($signed(s_axis_tdata[31:16]));
    in_ax       = 15'((in_x < 0) ? -in_x : in_x);
    in_ay       = 15'((in_y < 0) ? -in_y : in_y);
    div_in.x    = in_x;
    div_in.y_neg = (in_y < 0);
    div_in.ay   = in_ay;
    div_in.den  = 16'({1'b0, in_ax} + {1'b0, in_ay} + 16'd1);
    div_in.rem  = {1'b0, in_ax};
    div_in.quo  = '0;
  end

  // Stages 0..7: divider pipeline
  div_t dv_q [DivStages+1];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dv_q[0] <= div_in;
    end
  end

  for (genvar g = 1; g <= DivStages; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv[g]) begin
        dv_q[g] <= div_step2(dv_q[g-1]);
      end
    end
  end

  // Stage 8: slow wheel product ay * (ONE - t)
  logic signed [15:0] m8_x_q;
  logic               m8_yneg_q;
  logic        [14:0] m8_ay_q;
  logic        [29:0] m8_prod_q;

  always_ff @(posedge clk_i) begin
    if (adv[8]) begin
      m8_x_q    <= dv_q[DivStages].x;
      m8_yneg_q <= dv_q[DivStages].y_neg;
      m8_ay_q   <= dv_q[DivStages].ay;
      m8_prod_q <= dv_q[DivStages].ay * (OneU - {1'b0, dv_q[DivStages].quo});
    end
  end

  // Stage 9: arc values, alpha, blend products
  logic        [14:0] s9_slow, s9_lmag, s9_rmag, s9_alpha;
  logic        [15:0] s9_a2;
  logic signed [15:0] s9_arc_l, s9_arc_r, s9_alpha_s, s9_beta_s;
  logic signed [31:0] pa_l_q, pb_l_q, pa_r_q, pb_r_q;

  always_comb begin
    s9_slow    = m8_prod_q[28:14];
    s9_lmag    = (m8_x_q > 0) ? m8_ay_q : s9_slow;
    s9_rmag    = (m8_x_q > 0) ? s9_slow : m8_ay_q;
    s9_arc_l   = m8_yneg_q ? -$signed({1'b0, s9_lmag}) : $signed({1'b0, s9_lmag});
    s9_arc_r   = m8_yneg_q ? -$signed({1'b0, s9_rmag}) : $signed({1'b0, s9_rmag});
    s9_a2      = {m8_ay_q, 1'b0};
    s9_alpha   = (s9_a2 > {1'b0, OneU}) ? OneU : s9_a2[14:0];
    s9_alpha_s = $signed({1'b0, s9_alpha});
    s9_beta_s  = $signed({1'b0, 15'(OneU - s9_alpha)});
  end

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      pa_l_q <= s9_alpha_s * s9_arc_l;
      pb_l_q <= s9_beta_s * m8_x_q;
      pa_r_q <= s9_alpha_s * s9_arc_r;
      pb_r_q <= s9_beta_s * (-m8_x_q);
    end
  end

  // Stage 10: blended wheel values v
  logic signed [15:0] v_l_q, v_r_q;

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      v_l_q <= 16'(div_one_tz(pa_l_q + pb_l_q));
      v_r_q <= 16'(div_one_tz(pa_r_q + pb_r_q));
    end
  end

  // Stage 11: scale to PWM range
  logic signed [25:0] pw_l_q, pw_r_q;
  logic               f11_l_q, f11_r_q;

  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      pw_l_q  <= v_l_q * $signed({1'b0, PwmFull});
      pw_r_q  <= v_r_q * $signed({1'b0, PwmFull});
      f11_l_q <= !v_l_q[15];
      f11_r_q <= !v_r_q[15];
    end
  end

  // Stage 12: wheel speed magnitudes
  logic signed [11:0] s12_pl, s12_pr;
  logic        [9:0]  spd_l_q, spd_r_q;
  logic               f12_l_q, f12_r_q;

  always_comb begin
    s12_pl = 12'(div_one_tz(32'(pw_l_q)));
    s12_pr = 12'(div_one_tz(32'(pw_r_q)));
    if (s12_pl < 0) s12_pl = -s12_pl;
    if (s12_pr < 0) s12_pr = -s12_pr;
    if (s12_pl > PwmFullS) s12_pl = PwmFullS;
    if (s12_pr > PwmFullS) s12_pr = PwmFullS;
  end

  always_ff @(posedge clk_i) begin
    if (adv[12]) begin
      spd_l_q <= s12_pl[9:0];
      spd_r_q <= s12_pr[9:0];
      f12_l_q <= f11_l_q;
      f12_r_q <= f11_r_q;
    end
  end

  // Stage 13: correction gain; swap wheels onto opposite motors
  logic [24:0] dp_lm_q, dp_rm_q;
  logic        fwd_lm_q, fwd_rm_q;

  always_ff @(posedge clk_i) begin
    if (adv[13]) begin
      dp_lm_q  <= lcorr_q * spd_r_q;
      dp_rm_q  <= rcorr_q * spd_l_q;
      fwd_lm_q <= f12_r_q;
      fwd_rm_q <= f12_l_q;
    end
  end

  // Stage 14: round, saturate, output register
  logic [25:0] s14_rl, s14_rr;
  logic [11:0] s14_dl, s14_dr;
  logic [9:0]  duty_l_q, duty_r_q;
  logic        fwd_l_q, fwd_r_q;

  always_comb begin
    s14_rl = {1'b0, dp_lm_q} + CorrHalf;
    s14_rr = {1'b0, dp_rm_q} + CorrHalf;
    s14_dl = s14_rl[25:14];
    s14_dr = s14_rr[25:14];
  end

  always_ff @(posedge clk_i) begin
    if (adv[14]) begin
      duty_l_q <= (s14_dl > {2'b00, PwmFull}) ? PwmFull : s14_dl[9:0];
      duty_r_q <= (s14_dr > {2'b00, PwmFull}) ? PwmFull : s14_dr[9:0];
      fwd_l_q  <= fwd_lm_q;
      fwd_r_q  <= fwd_rm_q;
    end
  end

  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tdata  = {duty_r_q, !fwd_r_q, fwd_r_q, duty_l_q, !fwd_l_q, fwd_l_q};

endmodule

// ----- src/jddm_checker.sv -----
// ----------------------------------------------------------------------------
// jddm_checker - port-level checks for the joystick mixer
// Watches the stream ports of the top level and flags broken behavior.
// ----------------------------------------------------------------------------
module jddm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // Bridge lines of each motor are always complementary
  a_dir_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[1]) &&
                      (m_axis_tdata[12] != m_axis_tdata[13]))
    else $error("bridge direction lines not complementary");

  // Input backpressure only when the whole pipeline is full and stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while pipeline has room");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // No result right after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind joystick_differential_drive_mixer jddm_checker u_jddm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/mixer_drive_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixer_drive_checker - result checker for the joystick mixer
// Watches the stick, result and correction channels, predicts the bridge
// lines and duties of every accepted stick item and compares each result
// item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mixer_drive_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [31:0]                   in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [23:0]                   out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [jddm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [14:0]                   cfg_data_i,
  output int                            pending_o,
  output int                            fail_count_o
);

  import jddm_pkg::*;

  localparam longint Unity     = 16384;
  localparam longint PwmMax    = 1023;

  // last field in the lowest bits
  typedef struct packed {
    logic [9:0] right_duty;
    logic       right_in_two;
    logic       right_in_one;
    logic [9:0] left_duty;
    logic       left_in_two;
    logic       left_in_one;
  } drive_cmd_t;

  logic [14:0] left_gain;
  logic [14:0] right_gain;
  drive_cmd_t  expected_cmds[$];
  int          failures;

  assign fail_count_o = failures;

  function automatic longint clamp_axis(logic [15:0] raw);
    longint v;
    v = $signed(raw);
    if (v > Unity) v = Unity;
    if (v < -Unity) v = -Unity;
    return v;
  endfunction

  function automatic longint wheel_pwm(longint alpha, longint arc, longint tank,
                                       output bit fwd);
    longint v;
    longint pwm;
    v   = (alpha * arc + (Unity - alpha) * tank) / Unity;
    pwm = (v * PwmMax) / Unity;
    fwd = (v >= 0);
    if (pwm < 0) pwm = -pwm;
    if (pwm > PwmMax) pwm = PwmMax;
    return pwm;
  endfunction

  function automatic logic [9:0] gained_duty(logic [14:0] gain, longint speed);
    longint d;
    d = (longint'(gain) * speed + 8192) >>> 14;
    if (d > PwmMax) d = PwmMax;
    return d[9:0];
  endfunction

  function automatic drive_cmd_t predict_drive(logic [15:0] raw_x, logic [15:0] raw_y,
                                               logic [14:0] lgain, logic [14:0] rgain);
    drive_cmd_t cmd;
    longint     x, y, ax, ay, ratio, slow, arc_l, arc_r, alpha, spd_l, spd_r;
    bit         fwd_l, fwd_r;
    x     = clamp_axis(raw_x);
    y     = clamp_axis(raw_y);
    ax    = (x < 0) ? -x : x;
    ay    = (y < 0) ? -y : y;
    ratio = (ax * Unity) / (ax + ay + 1);
    slow  = (ay * (Unity - ratio)) / Unity;
    if (x > 0) begin
      arc_l = ay;
      arc_r = slow;
    end else begin
      arc_l = slow;
      arc_r = ay;
    end
    if (y < 0) begin
      arc_l = -arc_l;
      arc_r = -arc_r;
    end
    alpha = (2 * ay > Unity) ? Unity : 2 * ay;
    spd_l = wheel_pwm(alpha, arc_l, x, fwd_l);
    spd_r = wheel_pwm(alpha, arc_r, -x, fwd_r);
    // wheels cross over: left motor takes the right wheel and vice versa
    cmd.left_in_one  = fwd_r;
    cmd.left_in_two  = !fwd_r;
    cmd.left_duty    = gained_duty(lgain, spd_r);
    cmd.right_in_one = fwd_l;
    cmd.right_in_two = !fwd_l;
    cmd.right_duty   = gained_duty(rgain, spd_l);
    return cmd;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    end
  endtask

  initial failures = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    drive_cmd_t got;
    drive_cmd_t want;
    if (!rst_ni) begin
      left_gain  = 15'd16384;
      right_gain = 15'd16384;
      expected_cmds.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_addr_i)
          CFG_LEFT_CORR: begin
            left_gain = cfg_data_i;
          end
          CFG_RIGHT_CORR: begin
            right_gain = cfg_data_i;
          end
          default: begin
            // drop writes to unknown indexes
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_cmds.push_back(predict_drive(in_data_i[15:0], in_data_i[31:16],
                                              left_gain, right_gain));
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %h",
                   $time, out_data_i);
          failures++;
        end else begin
          want = expected_cmds.pop_front();
          check_field("left_in_one", want.left_in_one, got.left_in_one);
          check_field("left_in_two", want.left_in_two, got.left_in_two);
          check_field("left_duty", want.left_duty, got.left_duty);
          check_field("right_in_one", want.right_in_one, got.right_in_one);
          check_field("right_in_two", want.right_in_two, got.right_in_two);
          check_field("right_duty", want.right_duty, got.right_duty);
        end
      end
      pending_o <= expected_cmds.size();
    end
  end

endmodule

// ----- sim/tb_joystick_differential_drive_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_differential_drive_mixer - mixer regression bench
// Feeds directed and random stick samples under several correction gains,
// with random gaps on both channels and one long output hold-off, and lets
// the checker compare every result item.
// ----------------------------------------------------------------------------
module tb_joystick_differential_drive_mixer;

  import jddm_pkg::*;

  localparam int NumPhases      = 6;
  localparam int SamplesPerPhase = 240;
  localparam int HoldCycles     = 80;
  localparam int DrainCycles    = 40;
  localparam int CycleLimit     = 800000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // [15:0] stick_x, [31:16] stick_y
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [0] left_in_one, [1] left_in_two, [11:2] left_duty,
  // [12] right_in_one, [13] right_in_two, [23:14] right_duty
  logic [23:0]         m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [14:0]         cfg_data_i;

  int pending;
  int fail_count;
  int cycle_count;
  bit quiet_phase;
  bit hold_request;

  joystick_differential_drive_mixer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  mixer_drive_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_axis();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 2))
        0: v = 16384;
        1: v = -16384;
        default: v = 0;
      endcase
    end else if (r < 18) begin
      v = $urandom;           // any 16-bit pattern, out of range included
    end else if (r < 35) begin
      v = int'($urandom_range(0, 2048)) - 1024;
    end else begin
      v = int'($urandom_range(0, 32768)) - 16384;
    end
    return 16'(v);
  endfunction

  task automatic send_sample(logic [15:0] x, logic [15:0] y);
    int gap;
    s_axis_tdata  <= {y, x};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_gain(logic [CfgAddrW-1:0] idx, logic [14:0] value);
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // hold until every result item has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    quiet_phase   = 1'b0;
    hold_request  = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = CFG_LEFT_CORR;
    cfg_data_i    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corners, full-scale diagonals, zero throttle, out-of-range sticks
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd16384, 16'sd16384);
    send_sample(-16'sd16384, -16'sd16384);
    send_sample(16'sd16384, -16'sd16384);
    send_sample(-16'sd16384, 16'sd16384);
    send_sample(16'sd0, 16'sd16384);
    send_sample(16'sd0, -16'sd16384);
    send_sample(16'sd16384, 16'sd0);
    send_sample(-16'sd16384, 16'sd0);
    send_sample(16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sd16384, 16'sd1);
    send_sample(16'sd1, 16'sd1);
    send_sample(-16'sd1, -16'sd1);
    send_sample(16'sd8192, 16'sd4096);
    send_sample(-16'sd8192, -16'sd4096);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd20000, -16'sd20000);
    send_sample(16'hFFFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      quiet_phase = 1'b0;
      case (phase)
        1: begin
          write_gain(CFG_LEFT_CORR, 15'd32767);
          write_gain(CFG_RIGHT_CORR, 15'd0);
          write_gain(CfgAddrW'($urandom_range(2, 255)), 15'($urandom));
          write_gain(8'hFF, 15'd0);
          quiet_phase = 1'b1;
        end
        2: begin
          write_gain(CFG_LEFT_CORR, 15'd0);
          write_gain(CFG_RIGHT_CORR, 15'd32767);
        end
        3: begin
          write_gain(CFG_LEFT_CORR, 15'($urandom));
          write_gain(CFG_RIGHT_CORR, 15'($urandom));
        end
        4: begin
          write_gain(CFG_LEFT_CORR, 15'd32767);
          write_gain(CFG_RIGHT_CORR, 15'd32767);
        end
        5: begin
          write_gain(CFG_LEFT_CORR, 15'd16384);
          write_gain(CFG_RIGHT_CORR, 15'($urandom_range(12000, 24000)));
        end
        default: begin
          // keep the reset gains
        end
      endcase
      for (int n = 0; n < SamplesPerPhase; n++) begin
        // stall the output long enough to fill the pipeline and block input
        if (phase == 1 && n == 10) hold_request = 1'b1;
        send_sample(pick_axis(), pick_axis());
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
